@@ sv/cfae_pkg.sv @@
`timescale 1ns / 1ps

package cfae_pkg;

    // ascii codes of the fixed characters
    localparam logic [7:0] CHAR_CR      = 8'h0D;
    localparam logic [7:0] CHAR_EXT_DAT = 8'h54;  // 'T'
    localparam logic [7:0] CHAR_EXT_RMT = 8'h52;  // 'R'
    localparam logic [7:0] CHAR_STD_DAT = 8'h74;  // 't'
    localparam logic [7:0] CHAR_STD_RMT = 8'h72;  // 'r'
    localparam logic [7:0] CHAR_ERR     = 8'h45;  // 'E'

    localparam logic [3:0] NIBBLE_MASK  = 4'hF;
    localparam logic [3:0] MAX_BYTES    = 4'd8;

    // register indexes of the configuration port
    localparam logic CFG_TIMESTAMP_EN = 1'b0;
    localparam logic CFG_ERROR_EN     = 1'b1;

    // character source picked by the controller
    typedef enum logic [2:0] {
        SEL_HEAD,
        SEL_ID,
        SEL_DLC,
        SEL_DATA,
        SEL_TIME,
        SEL_CR
    } cfae_sel_t;

    typedef struct packed {
        logic      load;
        logic      emit;
        cfae_sel_t sel;
        logic [3:0] idx;
    } cfae_cmd_t;

    typedef struct packed {
        logic       kind;
        logic       ext;
        logic       rtr;
        logic       ts_en;
        logic       err_en;
        logic [3:0] byte_count;
        logic       slot_free;
    } cfae_sts_t;

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] c;
        if (nib < 4'd10)
        begin
            c = 8'h30 + {4'd0, nib};
        end
        else
        begin
            c = 8'h37 + {4'd0, nib};
        end
        return c;
    endfunction

endpackage

@@ sv/cfae_datapath.sv @@
`timescale 1ns / 1ps

module cfae_datapath
    import cfae_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cfae_cmd_t   cmd,
    output cfae_sts_t   sts,
    input  logic        kind,
    input  logic        extended_id,
    input  logic        remote_request,
    input  logic [28:0] identifier,
    input  logic [3:0]  length_code,
    input  logic [63:0] payload,
    input  logic [15:0] time_value,
    input  logic [7:0]  error_code,
    input  logic        cfg_valid,
    input  logic        cfg_index,
    input  logic        cfg_data,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  character,
    output logic        last
);

    logic        kind_reg;
    logic        ext_reg;
    logic        rtr_reg;
    logic [28:0] id_reg;
    logic [3:0]  dlc_reg;
    logic [63:0] data_reg;
    logic [15:0] time_reg;
    logic [7:0]  err_reg;

    logic        ts_en_reg;
    logic        err_en_reg;

    logic        valid_reg;
    logic        valid_next;
    logic [7:0]  char_reg;
    logic        last_reg;

    logic [31:0] id_ext_shift;
    logic [11:0] id_std_shift;
    logic [63:0] data_shift;
    logic [15:0] time_shift;
    logic [7:0]  err_shift;
    logic [3:0]  nib;
    logic [7:0]  char_next;

    // item capture
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg <= kind;
            ext_reg  <= extended_id;
            rtr_reg  <= remote_request;
            id_reg   <= identifier;
            dlc_reg  <= length_code;
            data_reg <= payload;
            time_reg <= time_value;
            err_reg  <= error_code;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ts_en_reg  <= 1'b0;
            err_en_reg <= 1'b0;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == CFG_TIMESTAMP_EN)
            begin
                ts_en_reg <= cfg_data;
            end
            if (cfg_index == CFG_ERROR_EN)
            begin
                err_en_reg <= cfg_data;
            end
        end
    end

    // nibble pick, index counts digit positions from the low end, except data: low byte first, high nibble first
    always_comb
    begin
        id_ext_shift = {3'd0, id_reg} >> {cmd.idx[2:0], 2'b00};
        id_std_shift = {1'b0, id_reg[10:0]} >> {cmd.idx[1:0], 2'b00};
        data_shift   = data_reg >> {cmd.idx[3:1], ~cmd.idx[0], 2'b00};
        time_shift   = time_reg >> {cmd.idx[1:0], 2'b00};
        err_shift    = err_reg >> {cmd.idx[0], 2'b00};
        nib          = 4'd0;
        char_next    = CHAR_CR;
        case (cmd.sel)
            SEL_HEAD:
            begin
                if (kind_reg)
                    char_next = CHAR_ERR;
                else if (ext_reg)
                    char_next = rtr_reg ? CHAR_EXT_RMT : CHAR_EXT_DAT;
                else
                    char_next = rtr_reg ? CHAR_STD_RMT : CHAR_STD_DAT;
            end
            SEL_ID:
            begin
                if (kind_reg)
                    nib = err_shift[3:0];
                else if (ext_reg)
                    nib = id_ext_shift[3:0];
                else
                    nib = id_std_shift[3:0];
                char_next = hex_char(nib & NIBBLE_MASK);
            end
            SEL_DLC:
            begin
                char_next = hex_char(dlc_reg);
            end
            SEL_DATA:
            begin
                char_next = hex_char(data_shift[3:0]);
            end
            SEL_TIME:
            begin
                char_next = hex_char(time_shift[3:0]);
            end
            SEL_CR:
            begin
                char_next = CHAR_CR;
            end
            default:
            begin
                char_next = CHAR_CR;
            end
        endcase
    end

    // output register
    always_comb
    begin
        valid_next = valid_reg;
        if (cmd.emit)
            valid_next = 1'b1;
        else if (!out_stall)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            char_reg <= char_next;
            last_reg <= (cmd.sel == SEL_CR);
        end
    end

    always_comb
    begin
        sts.kind       = kind_reg;
        sts.ext        = ext_reg;
        sts.rtr        = rtr_reg;
        sts.ts_en      = ts_en_reg;
        sts.err_en     = err_en_reg;
        sts.byte_count = (dlc_reg > MAX_BYTES) ? MAX_BYTES : dlc_reg;
        sts.slot_free  = !valid_reg || !out_stall;
    end

    assign out_valid = valid_reg;
    assign character = char_reg;
    assign last      = last_reg;

endmodule

@@ sv/cfae_ctrl.sv @@
`timescale 1ns / 1ps

module cfae_ctrl
    import cfae_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  cfae_sts_t sts,
    output cfae_cmd_t cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HEAD,
        ST_ID,
        ST_DLC,
        ST_DATA,
        ST_TIME,
        ST_CR
    } state_t;

    state_t     state_reg;
    state_t     state_next;
    logic [3:0] cnt_reg;
    logic [3:0] cnt_next;
    state_t     tail_state;
    logic [3:0] tail_cnt;
    logic [4:0] data_digits;
    logic [3:0] last_data;

    always_comb
    begin
        tail_state  = sts.ts_en ? ST_TIME : ST_CR;
        tail_cnt    = sts.ts_en ? 4'd3 : 4'd0;
        data_digits = {sts.byte_count, 1'b0} - 5'd1;
        last_data   = data_digits[3:0];

        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd.load   = 1'b0;
        cmd.emit   = 1'b0;
        cmd.sel    = SEL_CR;
        cmd.idx    = cnt_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_HEAD;
                end
            end
            ST_HEAD:
            begin
                cmd.sel = SEL_HEAD;
                if (sts.kind && !sts.err_en)
                begin
                    // error line suppressed
                    state_next = ST_IDLE;
                end
                else if (sts.slot_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_ID;
                    if (sts.kind)
                        cnt_next = 4'd1;
                    else if (sts.ext)
                        cnt_next = 4'd7;
                    else
                        cnt_next = 4'd2;
                end
            end
            ST_ID:
            begin
                cmd.sel = SEL_ID;
                if (sts.slot_free)
                begin
                    cmd.emit = 1'b1;
                    if (cnt_reg == 4'd0)
                    begin
                        state_next = sts.kind ? tail_state : ST_DLC;
                        cnt_next   = sts.kind ? tail_cnt : 4'd0;
                    end
                    else
                    begin
                        cnt_next = cnt_reg - 4'd1;
                    end
                end
            end
            ST_DLC:
            begin
                cmd.sel = SEL_DLC;
                if (sts.slot_free)
                begin
                    cmd.emit = 1'b1;
                    if (sts.rtr || sts.byte_count == 4'd0)
                    begin
                        state_next = tail_state;
                        cnt_next   = tail_cnt;
                    end
                    else
                    begin
                        state_next = ST_DATA;
                        cnt_next   = 4'd0;
                    end
                end
            end
            ST_DATA:
            begin
                cmd.sel = SEL_DATA;
                if (sts.slot_free)
                begin
                    cmd.emit = 1'b1;
                    if (cnt_reg == last_data)
                    begin
                        state_next = tail_state;
                        cnt_next   = tail_cnt;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + 4'd1;
                    end
                end
            end
            ST_TIME:
            begin
                cmd.sel = SEL_TIME;
                if (sts.slot_free)
                begin
                    cmd.emit = 1'b1;
                    if (cnt_reg == 4'd0)
                        state_next = ST_CR;
                    else
                        cnt_next = cnt_reg - 4'd1;
                end
            end
            ST_CR:
            begin
                cmd.sel = SEL_CR;
                if (sts.slot_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= 4'd0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    assign in_stall = (state_reg != ST_IDLE);

    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> state_reg == ST_IDLE)
        else $error("item captured while a line is in progress");

    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> sts.slot_free)
        else $error("character issued into a full output register");

    a_data_frame: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DATA |-> (!sts.rtr && !sts.kind && sts.byte_count != 4'd0))
        else $error("data digits for a line that carries none");

    a_cr_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit && cmd.sel == SEL_CR) |=> state_reg == ST_IDLE)
        else $error("line continues after carriage return");

endmodule

@@ sv/can_frame_ascii_encoder_top.sv @@
`timescale 1ns / 1ps

// channel | handshake            | beat contents
// --------+----------------------+----------------------------------------------
// in      | in_valid / in_stall  | kind, extended_id, remote_request, identifier,
//         |                      | length_code, payload, time_value, error_code
// out     | out_valid / out_stall| character, last (set on the carriage return)
// cfg     | cfg_valid / cfg_ready| cfg_index (0 timestamp, 1 error report),
//         |                      | cfg_data
//
// one character leaves per cycle while out_stall is low; an item is
// captured, then the controller walks the line one digit at a time
// a suppressed error beat is captured but gives no output
// in_stall stays high from capture until the last character is registered
// reset (rst_n, asynchronous) clears both configuration bits and the fsm

module can_frame_ascii_encoder_top
    import cfae_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        kind,
    input  logic        extended_id,
    input  logic        remote_request,
    input  logic [28:0] identifier,
    input  logic [3:0]  length_code,
    input  logic [63:0] payload,
    input  logic [15:0] time_value,
    input  logic [7:0]  error_code,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  character,
    output logic        last,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic        cfg_data
);

    cfae_cmd_t cmd;
    cfae_sts_t sts;

    // configuration writes are always taken
    assign cfg_ready = 1'b1;

    // sequencer: walks header, id, dlc, data, timestamp and end of line
    cfae_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    // item and config registers, hex digit pick, output register
    cfae_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .kind           (kind),
        .extended_id    (extended_id),
        .remote_request (remote_request),
        .identifier     (identifier),
        .length_code    (length_code),
        .payload        (payload),
        .time_value     (time_value),
        .error_code     (error_code),
        .cfg_valid      (cfg_valid),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .character      (character),
        .last           (last)
    );

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps

// line-ascii encoder bench
// every accepted frame or error beat is expanded here into the characters
// the encoder should emit; each output beat is checked against the oldest
// character still pending, in order, character and last flag both

module testbench;

    import cfae_pkg::*;

    // values of the kind field
    localparam logic KIND_FRAME = 1'b0;
    localparam logic KIND_ERROR = 1'b1;

    // one input beat, as the bench builds and drives it
    typedef struct packed {
        logic        kind;
        logic        ext;
        logic        rtr;
        logic [28:0] identifier;
        logic [3:0]  length_code;
        logic [63:0] payload;
        logic [15:0] time_value;
        logic [7:0]  error_code;
    } can_item_t;

    // one output beat as it should come out
    typedef struct packed {
        logic [7:0] ch;
        logic       eol;
    } char_beat_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;

    // every input held at a known value from time zero
    logic        in_valid = 1'b0;
    can_item_t   in_item = '0;
    logic        out_stall = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_index = 1'b0;
    logic        cfg_data = 1'b0;

    logic        in_stall;
    logic        out_valid;
    logic [7:0]  character;
    logic        last;
    logic        cfg_ready;

    // bench copy of the two configuration bits, both clear out of reset
    logic        ts_on = 1'b0;
    logic        err_on = 1'b0;

    // characters still owed by the encoder, oldest first
    char_beat_t  line_chars[$];

    int          mismatch_count = 0;

    // idling knobs, in percent of cycles
    int          send_idle_pct = 0;
    int          stall_pct = 0;

    // long receiver hold-off: requested by a test, counted down by the stall process
    int          hold_req = 0;
    int          hold_left = 0;

    can_frame_ascii_encoder_top dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .kind           (in_item.kind),
        .extended_id    (in_item.ext),
        .remote_request (in_item.rtr),
        .identifier     (in_item.identifier),
        .length_code    (in_item.length_code),
        .payload        (in_item.payload),
        .time_value     (in_item.time_value),
        .error_code     (in_item.error_code),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .character      (character),
        .last           (last),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always #10 clk = ~clk;

    // ------------------------------------------------------------------
    // expected line builder
    // ------------------------------------------------------------------

    function automatic logic [7:0] hex_ascii(input logic [3:0] nib);
        if (nib > 4'd9)
        begin
            return 8'h41 + 8'(nib - 4'd10);
        end
        return 8'h30 + 8'(nib);
    endfunction

    function automatic void add_char(input logic [7:0] ch, input logic eol);
        char_beat_t b;
        b.ch  = ch;
        b.eol = eol;
        line_chars.push_back(b);
    endfunction

    // expands one accepted beat into the characters of its line
    function automatic void predict_line(input can_item_t it);
        int nbytes;
        if (it.kind == KIND_ERROR)
        begin
            // error lines vanish entirely while reporting is off
            if (!err_on)
            begin
                return;
            end
            add_char(CHAR_ERR, 1'b0);
            add_char(hex_ascii(it.error_code[7:4]), 1'b0);
            add_char(hex_ascii(it.error_code[3:0]), 1'b0);
        end
        else
        begin
            if (it.ext)
            begin
                add_char(it.rtr ? CHAR_EXT_RMT : CHAR_EXT_DAT, 1'b0);
                // 29 bits as eight digits, the top one only 0 or 1
                for (int s = 28; s >= 0; s -= 4)
                begin
                    add_char(hex_ascii(4'(it.identifier >> s)), 1'b0);
                end
            end
            else
            begin
                // standard id: bits above 10 are dropped
                add_char(it.rtr ? CHAR_STD_RMT : CHAR_STD_DAT, 1'b0);
                add_char(hex_ascii({1'b0, it.identifier[10:8]}), 1'b0);
                add_char(hex_ascii(it.identifier[7:4]), 1'b0);
                add_char(hex_ascii(it.identifier[3:0]), 1'b0);
            end
            add_char(hex_ascii(it.length_code), 1'b0);
            if (!it.rtr)
            begin
                // length codes 9 to 15 still print just eight bytes
                nbytes = (it.length_code > 4'd8) ? 8 : int'(it.length_code);
                for (int i = 0; i < nbytes; i++)
                begin
                    add_char(hex_ascii(it.payload[8 * i + 4 +: 4]), 1'b0);
                    add_char(hex_ascii(it.payload[8 * i +: 4]), 1'b0);
                end
            end
        end
        if (ts_on)
        begin
            add_char(hex_ascii(it.time_value[15:12]), 1'b0);
            add_char(hex_ascii(it.time_value[11:8]), 1'b0);
            add_char(hex_ascii(it.time_value[7:4]), 1'b0);
            add_char(hex_ascii(it.time_value[3:0]), 1'b0);
        end
        add_char(CHAR_CR, 1'b1);
    endfunction

    // ------------------------------------------------------------------
    // beat builders
    // ------------------------------------------------------------------

    function automatic can_item_t make_frame(input logic ext, input logic rtr,
                                             input logic [28:0] id,
                                             input logic [3:0] dlc,
                                             input logic [63:0] data,
                                             input logic [15:0] tv);
        can_item_t it;
        it.kind        = KIND_FRAME;
        it.ext         = ext;
        it.rtr         = rtr;
        it.identifier  = id;
        it.length_code = dlc;
        it.payload     = data;
        it.time_value  = tv;
        // not used by frames, so anything goes
        it.error_code  = 8'($urandom);
        return it;
    endfunction

    function automatic can_item_t make_error(input logic [7:0] code,
                                             input logic [15:0] tv);
        can_item_t it;
        // frame fields are don't-care on an error beat, fill them with noise
        it.kind        = KIND_ERROR;
        it.ext         = 1'($urandom_range(1));
        it.rtr         = 1'($urandom_range(1));
        it.identifier  = 29'($urandom);
        it.length_code = 4'($urandom);
        it.payload     = {$urandom, $urandom};
        it.time_value  = tv;
        it.error_code  = code;
        return it;
    endfunction

    // mostly data frames with legal lengths, some remote, long-dlc and error beats
    function automatic can_item_t random_item();
        can_item_t it;
        it.kind        = ($urandom_range(99) < 20) ? KIND_ERROR : KIND_FRAME;
        it.ext         = 1'($urandom_range(1));
        it.rtr         = ($urandom_range(99) < 25);
        it.identifier  = 29'($urandom);
        it.length_code = ($urandom_range(99) < 15) ? 4'($urandom_range(15, 9))
                                                   : 4'($urandom_range(8));
        it.payload     = {$urandom, $urandom};
        it.time_value  = 16'($urandom);
        it.error_code  = 8'($urandom);
        // now and then pin a field at an extreme
        case ($urandom_range(9))
            0: it.identifier = '1;
            1: it.identifier = '0;
            2: it.payload = '0;
            3: it.payload = '1;
            4: it.time_value = '1;
            default: ;
        endcase
        return it;
    endfunction

    // ------------------------------------------------------------------
    // monitors
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string msg);
        $display("[%0t] check failed: %s", $realtime, msg);
        mismatch_count++;
    endtask

    // accepted input beats and register writes, seen at the rising edge
    always @(posedge clk)
    begin
        if (rst_n && cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_TIMESTAMP_EN: ts_on = cfg_data;
                CFG_ERROR_EN:     err_on = cfg_data;
                default: ;
            endcase
        end
        if (rst_n && in_valid && !in_stall)
        begin
            predict_line(in_item);
        end
    end

    // output beats against the oldest pending character
    always @(posedge clk)
    begin
        char_beat_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (line_chars.size() == 0)
            begin
                report_mismatch($sformatf("unexpected beat char 0x%02h last %0b",
                                          character, last));
            end
            else
            begin
                want = line_chars.pop_front();
                if (character !== want.ch)
                begin
                    report_mismatch($sformatf("character 0x%02h, wanted 0x%02h",
                                              character, want.ch));
                end
                if (last !== want.eol)
                begin
                    report_mismatch($sformatf("last %0b, wanted %0b on char 0x%02h",
                                              last, want.eol, want.ch));
                end
            end
        end
    end

    // receiver: random stall, or a long hold-off when a test asks for one
    always @(negedge clk)
    begin
        if (hold_req != 0)
        begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left != 0)
        begin
            out_stall <= 1'b1;
            hold_left--;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------

    // offers one beat and returns once it is taken; valid is left high so
    // back-to-back beats need no gap
    task automatic offer_item(input can_item_t it);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_item  <= it;
        in_valid <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!(in_valid && !in_stall));
    endtask

    // sender stops and waits for every pending character, then a few cycles
    // more since a suppressed error beat may still be in flight
    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (line_chars.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_config(input logic ts, input logic err);
        wait_idle();
        write_reg(CFG_TIMESTAMP_EN, ts);
        write_reg(CFG_ERROR_EN, err);
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // reset configuration: no timestamp, error beats swallowed
    task automatic test_reset_defaults();
        offer_item(make_frame(1'b0, 1'b0, 29'h0, 4'd0, 64'h0, 16'h0));
        // high id bits must not leak into a standard id
        offer_item(make_frame(1'b0, 1'b0, '1, 4'd8, '1, '1));
        offer_item(make_frame(1'b1, 1'b0, '1, 4'd15, 64'h0123456789ABCDEF, 16'h0));
        offer_item(make_frame(1'b1, 1'b1, 29'h0ABCDEF1, 4'd8, {$urandom, $urandom},
                              16'h1234));
        offer_item(make_frame(1'b0, 1'b1, 29'h5A5, 4'd15, '1, 16'h8000));
        offer_item(make_error(8'hFF, 16'hFFFF));
        offer_item(make_frame(1'b0, 1'b0, 29'h123, 4'd9, 64'hFEDCBA9876543210,
                              16'h0001));
    endtask

    // three combinations of the two bits, all but both off, with timestamp and error extremes
    task automatic test_config_combinations();
        set_config(1'b1, 1'b1);
        offer_item(make_error(8'h00, 16'h0000));
        offer_item(make_error(8'hFF, 16'hFFFF));
        offer_item(make_frame(1'b1, 1'b0, 29'h0, 4'd0, 64'h0, 16'hA5C3));
        offer_item(make_frame(1'b0, 1'b0, 29'h7FF, 4'd1, '1, 16'hFFFF));
        offer_item(make_frame(1'b1, 1'b0, 29'h12345678, 4'd12, 64'h89ABCDEF01234567,
                              16'h0F0F));
        offer_item(make_error(8'h5A, 16'h1234));
        set_config(1'b0, 1'b1);
        offer_item(make_error(8'hA5, 16'($urandom)));
        offer_item(make_frame(1'b0, 1'b1, 29'h0, 4'd0, 64'h0, 16'($urandom)));
        set_config(1'b1, 1'b0);
        offer_item(make_error(8'h3C, 16'($urandom)));
        offer_item(make_frame(1'b1, 1'b1, 29'h1F0F0F0F, 4'd4, '1, 16'h0000));
        offer_item(make_frame(1'b0, 1'b0, 29'h1FFFF800, 4'd8, {$urandom, $urandom},
                              16'hC0DE));
    endtask

    task automatic test_random_phase(input int count, input logic ts, input logic err,
                                     input int send_pct, input int recv_pct);
        set_config(ts, err);
        send_idle_pct = send_pct;
        stall_pct     = recv_pct;
        repeat (count) offer_item(random_item());
    endtask

    // receiver holds off well past one line while the sender keeps offering,
    // so the encoder has to stall its input
    task automatic test_receiver_holdoff();
        send_idle_pct = 0;
        stall_pct     = 0;
        @(posedge clk);
        hold_req = 150;
        repeat (6) offer_item(make_frame(1'($urandom_range(1)), 1'b0, 29'($urandom),
                                         4'd8, {$urandom, $urandom}, 16'($urandom)));
    endtask

    // sender drains the encoder completely mid stream, then carries on
    task automatic test_sender_pause();
        set_config(1'b0, 1'b0);
        send_idle_pct = 31;
        stall_pct     = 54;
        repeat (4) offer_item(random_item());
        wait_idle();
        repeat (4) offer_item(random_item());
    endtask

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------

    initial
    begin
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_defaults();
        test_config_combinations();
        test_random_phase(110, 1'b1, 1'b1, 31, 54);
        test_random_phase(110, 1'b0, 1'b1, 54, 31);
        test_random_phase(80, 1'b1, 1'b1, 0, 0);
        test_receiver_holdoff();
        test_sender_pause();

        // let the last line out, then a little slack for anything stray
        wait_idle();
        repeat (40) @(posedge clk);
        if (line_chars.size() != 0)
        begin
            report_mismatch($sformatf("%0d characters never arrived", line_chars.size()));
        end

        if (mismatch_count == 0)
        begin
            $display("No mismatches found");
        end
        else
        begin
            $display("Mismatches found");
        end
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial
    begin
        #20_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule

@@ filelist.f @@
sv/cfae_pkg.sv
sv/cfae_datapath.sv
sv/cfae_ctrl.sv
sv/can_frame_ascii_encoder_top.sv
tb/sv/testbench.sv
